[src/bsrm_pkg.sv]
package bsrm_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_MAP    = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_UNMAP  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_ALLOC,
    ST_SCAN,
    ST_WIPE
  } state_e;

  localparam int PageShift = 12;
  localparam int VpW       = 20;
  localparam int PagesW    = 9;
  localparam int ShareW    = 7;
  localparam logic [ShareW-1:0] ShareMax = 7'd127;

  typedef struct packed {
    logic              valid;
    logic [VpW-1:0]    base;
    logic [PagesW-1:0] pages;
  } range_t;

  localparam range_t RangeReset = '{valid: 1'b0, base: 20'hFFFFF, pages: 9'd0};

  typedef struct packed {
    logic              in_use;
    logic [ShareW-1:0] share;
  } store_t;

  typedef struct packed {
    logic   en;
    store_t data;
  } store_wr_t;

endpackage

[src/bsrm_range_ram.sv]
module bsrm_range_ram #(
  parameter int AW = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  bsrm_pkg::range_t  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output bsrm_pkg::range_t  rdata_o
);

  bsrm_pkg::range_t mem_q [2**AW];
  bsrm_pkg::range_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bsrm_store_tbl.sv]
module bsrm_store_tbl #(
  parameter int NUM_STORES = 16,
  parameter int SW         = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsrm_pkg::store_wr_t  wr_i,
  input  logic [SW-1:0]        widx_i,
  input  logic [SW-1:0]        ridx_i,
  output bsrm_pkg::store_t     rdata_o
);

  bsrm_pkg::store_t tbl_q [NUM_STORES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STORES; i++) begin
        tbl_q[i] <= '0;
      end
    end else if (wr_i.en && (32'(widx_i) < NUM_STORES)) begin
      tbl_q[widx_i] <= wr_i.data;
    end
  end

  assign rdata_o = (32'(ridx_i) < NUM_STORES) ? tbl_q[ridx_i] : '0;

endmodule

[src/backing_store_range_map_top.sv]
// Backing-store range map.
// Request channel: present opcode_i and its arguments with start_i high; the
// request is taken at a rising edge where start_i is high and busy_o is low.
// Result channel: done_o is high for exactly one cycle with status_o,
// found_store_o and page_offset_o; the receiver cannot stall it. busy_o drops
// in the cycle done_o rises, so the next request may be taken right then.
// Each request goes through ST_EXEC first, and then, by opcode
// (S = NUM_STORES, P = NUM_PROCS rounded up to a power of two):
//   map, bad arguments, unknown opcode : ends in ST_EXEC
//   allocate                           : ST_ALLOC, up to S stores, one store a cycle
//   lookup, unmap                      : ST_SCAN, up to S stores, by one range
//                                        memory read per store, pipelined
//   free, or unmap that frees the store: ST_WIPE then clears P range entries,
//                                        one a cycle through the write port
// Reset: after rst_ni rises, a clearing pass writes every range memory entry,
// S rounded up to a power of two times P entries (1024 by default), with busy_o
// high. The store flags and share counts clear at once.
module backing_store_range_map_top #(
  parameter int NUM_STORES      = 16,
  parameter int NUM_PROCS       = 64,
  parameter int PAGES_PER_STORE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic [5:0]  process_id_i,
  input  logic [4:0]  store_index_i,
  input  logic [19:0] virtual_page_i,
  input  logic [8:0]  page_count_i,
  input  logic [31:0] virt_addr_i,
  output logic        done_o,
  output logic        status_o,
  output logic [3:0]  found_store_o,
  output logic [7:0]  page_offset_o
);

  localparam int SW = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
  localparam int PW = $clog2(NUM_PROCS);
  localparam int AW = SW + PW;

  bsrm_pkg::state_e state_q, state_d;
  logic [2:0]                   op_q, op_d;
  logic [5:0]                   pid_q, pid_d;
  logic [4:0]                   sidx_q, sidx_d;
  logic [bsrm_pkg::VpW-1:0]     vp_q, vp_d;
  logic [bsrm_pkg::PagesW-1:0]  npg_q, npg_d;
  logic [SW:0]                  scan_q, scan_d;
  logic [SW-1:0]                chk_q, chk_d;
  logic                         chk_v_q, chk_v_d;
  logic [AW-1:0]                clr_q, clr_d;
  logic [SW-1:0]                wipe_q, wipe_d;
  logic                         done_q, done_d;
  logic                         status_q, status_d;
  logic [3:0]                   store_q, store_d;
  logic [7:0]                   off_q, off_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  bsrm_pkg::range_t     ram_wdata, ram_rdata;
  bsrm_pkg::store_wr_t  tbl_wr;
  logic [SW-1:0]        tbl_widx, tbl_ridx;
  bsrm_pkg::store_t     tbl_rd;

  logic                              pid_ok, sidx_ok, npg_ok;
  logic [PW-1:0]                     pid_idx;
  logic [SW-1:0]                     sidx_idx;
  logic                              scan_end;
  logic [bsrm_pkg::VpW-1:0]          diff;
  logic                              hit;
  logic                              clr_last_init, clr_last_wipe;
  logic [bsrm_pkg::ShareW-1:0]       share_dec, share_inc;

  bsrm_range_ram #(.AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bsrm_store_tbl #(.NUM_STORES(NUM_STORES), .SW(SW)) u_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tbl_wr),
    .widx_i  (tbl_widx),
    .ridx_i  (tbl_ridx),
    .rdata_o (tbl_rd)
  );

  assign pid_ok   = 32'(pid_q) < NUM_PROCS;
  assign sidx_ok  = 32'(sidx_q) < NUM_STORES;
  assign npg_ok   = (npg_q != '0) && (32'(npg_q) <= PAGES_PER_STORE);
  assign pid_idx  = PW'(pid_q);
  assign sidx_idx = SW'(sidx_q);
  assign scan_end = scan_q == (SW+1)'(NUM_STORES);

  assign diff = vp_q - ram_rdata.base;
  assign hit  = chk_v_q && ram_rdata.valid && (ram_rdata.base <= vp_q) &&
                (diff < bsrm_pkg::VpW'(ram_rdata.pages));

  assign clr_last_init = &clr_q;
  assign clr_last_wipe = &clr_q[PW-1:0];

  assign share_dec = (tbl_rd.share != '0) ? tbl_rd.share - 1'b1 : '0;
  assign share_inc = (tbl_rd.share != bsrm_pkg::ShareMax) ? tbl_rd.share + 1'b1
                                                          : tbl_rd.share;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsrm_pkg::ST_INIT: begin
        if (clr_last_init) state_d = bsrm_pkg::ST_IDLE;
      end
      bsrm_pkg::ST_IDLE: begin
        if (start_i) state_d = bsrm_pkg::ST_EXEC;
      end
      bsrm_pkg::ST_EXEC: begin
        unique case (bsrm_pkg::op_e'(op_q)) inside
          bsrm_pkg::OP_ALLOC: state_d = bsrm_pkg::ST_ALLOC;
          bsrm_pkg::OP_FREE:  state_d = sidx_ok ? bsrm_pkg::ST_WIPE : bsrm_pkg::ST_IDLE;
          bsrm_pkg::OP_LOOKUP, bsrm_pkg::OP_UNMAP:
            state_d = pid_ok ? bsrm_pkg::ST_SCAN : bsrm_pkg::ST_IDLE;
          default:            state_d = bsrm_pkg::ST_IDLE;
        endcase
      end
      bsrm_pkg::ST_ALLOC: begin
        if (scan_end || !tbl_rd.in_use) state_d = bsrm_pkg::ST_IDLE;
      end
      bsrm_pkg::ST_SCAN: begin
        if (hit) begin
          if (op_q == bsrm_pkg::OP_UNMAP && share_dec == '0) begin
            state_d = bsrm_pkg::ST_WIPE;
          end else begin
            state_d = bsrm_pkg::ST_IDLE;
          end
        end else if (scan_end && !chk_v_q) begin
          state_d = bsrm_pkg::ST_IDLE;
        end
      end
      bsrm_pkg::ST_WIPE: begin
        if (clr_last_wipe) state_d = bsrm_pkg::ST_IDLE;
      end
      default: state_d = bsrm_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d      = op_q;
    pid_d     = pid_q;
    sidx_d    = sidx_q;
    vp_d      = vp_q;
    npg_d     = npg_q;
    scan_d    = scan_q;
    chk_d     = chk_q;
    chk_v_d   = 1'b0;
    clr_d     = clr_q;
    wipe_d    = wipe_q;
    done_d    = 1'b0;
    status_d  = status_q;
    store_d   = store_q;
    off_d     = off_q;
    ram_we    = 1'b0;
    ram_waddr = {sidx_idx, pid_idx};
    ram_wdata = bsrm_pkg::RangeReset;
    ram_raddr = {scan_q[SW-1:0], pid_idx};
    tbl_wr    = '0;
    tbl_widx  = sidx_idx;
    tbl_ridx  = sidx_idx;

    unique case (state_q)
      bsrm_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      bsrm_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d   = opcode_i;
          pid_d  = process_id_i;
          sidx_d = store_index_i;
          npg_d  = page_count_i;
          vp_d   = (opcode_i == bsrm_pkg::OP_LOOKUP) ?
                   virt_addr_i[31:bsrm_pkg::PageShift] : virtual_page_i;
        end
      end
      bsrm_pkg::ST_EXEC: begin
        status_d = 1'b1;
        store_d  = '0;
        off_d    = '0;
        unique case (bsrm_pkg::op_e'(op_q)) inside
          bsrm_pkg::OP_ALLOC: begin
            scan_d = '0;
          end
          bsrm_pkg::OP_FREE: begin
            if (sidx_ok) begin
              status_d = 1'b0;
              tbl_wr   = '0;
              tbl_wr.en = 1'b1;
              wipe_d   = sidx_idx;
              clr_d    = '0;
            end else begin
              done_d = 1'b1;
            end
          end
          bsrm_pkg::OP_MAP: begin
            done_d = 1'b1;
            if (npg_ok && sidx_ok && pid_ok) begin
              status_d  = 1'b0;
              ram_we    = 1'b1;
              ram_wdata = '{valid: 1'b1, base: vp_q, pages: npg_q};
              tbl_wr    = '{en: 1'b1, data: '{in_use: 1'b1, share: share_inc}};
            end
          end
          bsrm_pkg::OP_LOOKUP, bsrm_pkg::OP_UNMAP: begin
            scan_d = '0;
            if (!pid_ok) done_d = 1'b1;
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end
      bsrm_pkg::ST_ALLOC: begin
        tbl_ridx = scan_q[SW-1:0];
        if (scan_end) begin
          done_d = 1'b1;
        end else if (!tbl_rd.in_use) begin
          done_d   = 1'b1;
          status_d = 1'b0;
          store_d  = 4'(scan_q);
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      bsrm_pkg::ST_SCAN: begin
        tbl_ridx = chk_q;
        tbl_widx = chk_q;
        if (hit) begin
          status_d = 1'b0;
          store_d  = 4'(chk_q);
          off_d    = diff[7:0];
          if (op_q == bsrm_pkg::OP_UNMAP) begin
            ram_we    = 1'b1;
            ram_waddr = {chk_q, pid_idx};
            tbl_wr    = '{en: 1'b1,
                          data: '{in_use: (share_dec != '0) && tbl_rd.in_use,
                                  share: share_dec}};
            if (share_dec == '0) begin
              wipe_d = chk_q;
              clr_d  = '0;
            end else begin
              done_d = 1'b1;
            end
          end else begin
            done_d = 1'b1;
          end
        end else if (!scan_end) begin
          chk_d   = scan_q[SW-1:0];
          chk_v_d = 1'b1;
          scan_d  = scan_q + 1'b1;
        end else if (!chk_v_q) begin
          done_d = 1'b1;
        end
      end
      bsrm_pkg::ST_WIPE: begin
        ram_we    = 1'b1;
        ram_waddr = {wipe_q, clr_q[PW-1:0]};
        clr_d     = clr_q + 1'b1;
        if (clr_last_wipe) done_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsrm_pkg::ST_INIT;
      scan_q  <= '0;
      chk_v_q <= 1'b0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      chk_v_q <= chk_v_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pid_q    <= pid_d;
    sidx_q   <= sidx_d;
    vp_q     <= vp_d;
    npg_q    <= npg_d;
    chk_q    <= chk_d;
    wipe_q   <= wipe_d;
    status_q <= status_d;
    store_q  <= store_d;
    off_q    <= off_d;
  end

  assign busy_o        = state_q != bsrm_pkg::ST_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_store_o = store_q;
  assign page_offset_o = off_q;

endmodule
